// File: hw/rtl/assert_macros.svh
// assertion macros for the rtl, used by line_follow_pi_steering
// expects signals named clk and rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define LFPS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LFPS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/lfps_pkg.sv
// types and constants for the line follower steering block
// no dependencies
`default_nettype none

package lfps_pkg;

    localparam int GAIN_W      = 16;
    localparam int MUL_CNT_W   = 4;
    localparam int DIV_W       = 40;
    localparam int DIV_CNT_W   = 6;
    localparam int REM_W       = 11;
    localparam int E_W         = 11;
    localparam int RAW_W       = 12;
    localparam int G_W         = 34;
    localparam int NB_W        = 38;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 16;
    localparam int DMAG_W      = 7;

    localparam logic [REM_W-1:0] HEAD_MOD  = 11'd1440;
    localparam logic [REM_W-1:0] HEAD_HALF = 11'd720;
    localparam logic [REM_W-1:0] DIV_TEN   = 11'd10;
    localparam logic [REM_W-1:0] DIV_SIX   = 11'd6;

    localparam int RAW_SHIFT   = 16;
    localparam int GYRO_SHIFT  = 11;
    localparam int D_SHIFT     = 17;
    localparam int C8_SHIFT    = 9;
    localparam int BIAS_ROUND  = 5;
    localparam int SPEED_MAX   = 28160;
    localparam int SPEED_FLOOR = 1280;
    localparam int SPEED_REV   = -256;

    localparam logic [DMAG_W-1:0] DMAG_MAX  = 7'd127;
    localparam logic [DMAG_W-1:0] STEER_MAX = 7'd100;
    localparam logic [DMAG_W-1:0] HARD_TURN = 7'd70;

    localparam logic [CFG_IDX_W-1:0] CFG_KP       = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KI       = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KG       = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LBASE    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RBASE    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOST    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF  = 4'd7;

    localparam logic [1:0] MODE_HOLDOFF = 2'd0;
    localparam logic [1:0] MODE_GYRO    = 2'd1;
    localparam logic [1:0] MODE_OFFLINE = 2'd2;

    typedef struct packed {
        logic               paused;
        logic [6:0]         left_inner;
        logic [6:0]         left_outer;
        logic [6:0]         right_inner;
        logic [6:0]         right_outer;
        logic signed [23:0] heading;
        logic [31:0]        now_ms;
    } in_item_t;

    typedef struct packed {
        logic               drive_on;
        logic signed [7:0]  steer_target;
        logic signed [15:0] left_speed;
        logic signed [15:0] right_speed;
        logic [1:0]         assist_mode;
    } out_item_t;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_HDIV  = 9'b000000010,
        S_MKP   = 9'b000000100,
        S_MKI   = 9'b000001000,
        S_MG    = 9'b000010000,
        S_SCALE = 9'b000100000,
        S_DDIV  = 9'b001000000,
        S_BDIV  = 9'b010000000,
        S_FIN   = 9'b100000000
    } seq_state_t;

endpackage

`default_nettype wire

// File: hw/rtl/lfps_mul.sv
// bit-serial shift-add multiplier, signed operand times 16-bit unsigned gain
// depends on lfps_pkg
`default_nettype none

module lfps_mul
    import lfps_pkg::*;
#(
    parameter int AW = 34
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic signed [AW-1:0]        a,
    input  wire logic [GAIN_W-1:0]           b,
    output logic                             done,
    output logic signed [AW+GAIN_W-1:0]      p
);

    logic signed [AW+GAIN_W-1:0] mcand_reg;
    logic signed [AW+GAIN_W-1:0] prod_reg;
    logic [GAIN_W-1:0]           mplier_reg;
    logic [MUL_CNT_W-1:0]        cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == MUL_CNT_W'(GAIN_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg  <= (AW+GAIN_W)'(a);
            mplier_reg <= b;
            prod_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                prod_reg <= prod_reg + mcand_reg;
            end
            mcand_reg  <= mcand_reg <<< 1;
            mplier_reg <= mplier_reg >> 1;
        end
    end

    assign done = done_reg;
    assign p    = prod_reg;

endmodule

`default_nettype wire

// File: hw/rtl/lfps_div.sv
// bit-serial restoring divider by a small unsigned divisor
// depends on lfps_pkg
`default_nettype none

module lfps_div
    import lfps_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DIV_W-1:0] dividend,
    input  wire logic [REM_W-1:0] divisor,
    output logic                  done,
    output logic [DIV_W-1:0]      quotient,
    output logic [REM_W-1:0]      remainder
);

    logic [DIV_W-1:0]     quo_reg;
    logic [REM_W-1:0]     rem_reg;
    logic [REM_W-1:0]     dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [REM_W:0]       trial;
    logic [REM_W:0]       diff;
    logic                 ge;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// File: hw/rtl/line_follow_pi_steering.sv
// line follower steering: one control tick in, one drive command out. The time
// from accepting an item to the next possible acceptance is set by the
// bit-serial divider (40 steps, run three times per item when gyro assist is
// active and twice otherwise) and the 16-step serial multiplier (run three
// times), plus the accept, scale and hand-off steps; a paused item goes from
// accept straight to hand-off.
// A new item is taken once the previous one has reached the output register; a
// stalled output register holds the sequencer in its last step.
// depends on lfps_pkg, lfps_mul, lfps_div and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module line_follow_pi_steering
    import lfps_pkg::*;
#(
    parameter int SUM_BITS     = 24,
    parameter int HEADING_BITS = 24
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire in_item_t              in_data,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output out_item_t                  out_data,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int MW = (SUM_BITS > G_W) ? SUM_BITS : G_W;
    localparam int PW = MW + GAIN_W;
    localparam int CW = PW + 2;
    localparam int TW = PW - GYRO_SHIFT;
    localparam int XW = TW + 2;
    localparam int YW = XW + 3;
    localparam int SW = CW + 1;

    // configuration
    logic [15:0] kp_reg, ki_reg, kg_reg, holdoff_reg;
    logic [8:0]  window_reg;
    logic [6:0]  lbase_reg, rbase_reg, boost_reg;

    // state and sequencer
    seq_state_t                 state_reg, state_next;
    logic signed [SUM_BITS-1:0] sum_reg;
    logic signed [31:0]         bias_reg;
    logic [31:0]                last_reg;

    logic signed [E_W-1:0]   e2_reg;
    logic                    paused_reg, assist_reg, offline_reg, hneg_reg;
    logic signed [RAW_W-1:0] raw_reg;
    logic signed [CW-1:0]    acc_reg;
    logic signed [XW-1:0]    x_reg;
    logic                    dneg_reg, nneg_reg;
    logic [DMAG_W-1:0]       dmag_reg;
    out_item_t               out_reg;
    logic                    out_valid_reg;

    // units
    logic                    mul_start, mul_done;
    logic signed [MW-1:0]    mul_a;
    logic [GAIN_W-1:0]       mul_b;
    logic signed [PW-1:0]    mul_p;
    logic                    div_start, div_done;
    logic [DIV_W-1:0]        div_dvd, div_q;
    logic [REM_W-1:0]        div_dvs, div_r;

    lfps_mul #(.AW(MW)) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    lfps_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // capture path
    logic [E_W-1:0]              e_pos, e_neg;
    logic signed [E_W-1:0]       e2_calc;
    logic [E_W-2:0]              e2_abs_in, e2_abs;
    logic signed [SUM_BITS:0]    sum_wide, sum_max, sum_min;
    logic signed [SUM_BITS-1:0]  sum_sat;
    logic                        near, late;
    logic [31:0]                 elapsed, hz;
    logic [HEADING_BITS-1:0]     hs_bits, habs;
    logic                        hneg;

    assign e_pos = {3'b0, in_data.right_inner, 1'b0} + {4'b0, in_data.right_outer}
                 + {3'b0, in_data.right_outer, 1'b0};
    assign e_neg = {3'b0, in_data.left_inner, 1'b0} + {4'b0, in_data.left_outer}
                 + {3'b0, in_data.left_outer, 1'b0};
    assign e2_calc   = $signed(e_pos - e_neg);
    assign e2_abs_in = e2_calc[E_W-1] ? (E_W-1)'(-e2_calc) : e2_calc[E_W-2:0];
    assign e2_abs    = e2_reg[E_W-1] ? (E_W-1)'(-e2_reg) : e2_reg[E_W-2:0];

    assign sum_wide = (SUM_BITS+1)'(sum_reg) + (SUM_BITS+1)'(e2_calc);
    assign sum_max  = {2'b00, {(SUM_BITS-1){1'b1}}};
    assign sum_min  = {2'b11, {(SUM_BITS-1){1'b0}}};
    always_comb
    begin
        priority if (sum_wide > sum_max)
            sum_sat = sum_max[SUM_BITS-1:0];
        else if (sum_wide < sum_min)
            sum_sat = sum_min[SUM_BITS-1:0];
        else
            sum_sat = sum_wide[SUM_BITS-1:0];
    end

    assign near    = e2_abs_in <= {1'b0, window_reg};
    assign elapsed = in_data.now_ms - last_reg;
    assign late    = elapsed >= {16'b0, holdoff_reg};

    assign hz      = 32'($unsigned(in_data.heading));
    assign hs_bits = hz[HEADING_BITS-1:0];
    assign hneg    = hs_bits[HEADING_BITS-1];
    assign habs    = hneg ? (~hs_bits + 1'b1) : hs_bits;

    // heading error path
    logic [RAW_W-1:0]        rem_ext;
    logic signed [RAW_W-1:0] rr, raw_calc;
    logic signed [G_W-1:0]   g_calc;
    logic signed [TW-1:0]    gterm;
    logic signed [YW-1:0]    y_calc;
    logic [YW-1:0]           ymag;
    logic signed [NB_W-1:0]  nb;
    logic [NB_W-1:0]         nmag;

    assign rem_ext  = {1'b0, div_r};
    assign rr       = (div_r >= HEAD_HALF) ? $signed(rem_ext - {1'b0, HEAD_MOD})
                                           : $signed(rem_ext);
    assign raw_calc = hneg_reg ? -rr : rr;
    assign g_calc   = (G_W'(raw_reg) <<< RAW_SHIFT) - G_W'(bias_reg);
    assign gterm    = $signed(mul_p[PW-1:GYRO_SHIFT]);
    assign y_calc   = (YW'(x_reg) <<< 3) - YW'(x_reg);
    assign ymag     = y_calc[YW-1] ? $unsigned(-y_calc) : $unsigned(y_calc);
    assign nb       = (NB_W'(bias_reg) <<< 3) + NB_W'(bias_reg)
                    + (NB_W'(raw_reg) <<< RAW_SHIFT);
    assign nmag     = nb[NB_W-1] ? $unsigned(-nb) : $unsigned(nb);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        mul_start  = 1'b0;
        div_start  = 1'b0;
        div_dvd    = DIV_W'(habs);
        div_dvs    = HEAD_MOD;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_data.paused)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = S_HDIV;
                    end
                end
            end
            S_HDIV:
            begin
                if (div_done)
                begin
                    mul_start  = 1'b1;
                    state_next = S_MKP;
                end
            end
            S_MKP:
            begin
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    state_next = S_MKI;
                end
            end
            S_MKI:
            begin
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    state_next = S_MG;
                end
            end
            S_MG:
            begin
                if (mul_done)
                begin
                    state_next = S_SCALE;
                end
            end
            S_SCALE:
            begin
                div_start  = 1'b1;
                div_dvd    = assist_reg ? DIV_W'(ymag[YW-1:D_SHIFT]) : DIV_W'(e2_abs);
                div_dvs    = assist_reg ? DIV_TEN : DIV_SIX;
                state_next = S_DDIV;
            end
            S_DDIV:
            begin
                if (div_done)
                begin
                    if (assist_reg)
                    begin
                        div_start  = 1'b1;
                        div_dvd    = DIV_W'(nmag) + DIV_W'(BIAS_ROUND);
                        div_dvs    = DIV_TEN;
                        state_next = S_BDIV;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_BDIV:
            begin
                if (div_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        unique case (state_reg)
            S_HDIV:
            begin
                mul_a = MW'(e2_reg);
                mul_b = kp_reg;
            end
            S_MKP:
            begin
                mul_a = MW'(sum_reg);
                mul_b = ki_reg;
            end
            default:
            begin
                mul_a = MW'(g_calc);
                mul_b = kg_reg;
            end
        endcase
    end

    // drive command
    logic signed [SW-1:0]     c8, lb, rb, boost, lsp, rsp, lsp_c, rsp_c;
    logic [DMAG_W-1:0]        smag;
    out_item_t                out_calc;

    assign c8    = SW'($signed(acc_reg[CW-1:C8_SHIFT]));
    assign lb    = SW'($signed({1'b0, lbase_reg, 8'b0}));
    assign rb    = SW'($signed({1'b0, rbase_reg, 8'b0}));
    assign boost = SW'($signed({1'b0, boost_reg, 8'b0}));
    assign smag  = (dmag_reg > STEER_MAX) ? STEER_MAX : dmag_reg;

    always_comb
    begin
        priority if (dmag_reg == '0)
        begin
            lsp = lb;
            rsp = rb;
        end
        else if (!dneg_reg)
        begin
            lsp = lb + boost;
            rsp = (dmag_reg >= HARD_TURN) ? SW'(SPEED_REV) : '0;
        end
        else
        begin
            rsp = rb + boost;
            lsp = (dmag_reg >= HARD_TURN) ? SW'(SPEED_REV) : '0;
        end
        if (!acc_reg[CW-1])
        begin
            rsp = rb - c8;
            if (rsp < SW'(SPEED_FLOOR))
                rsp = SW'(SPEED_FLOOR);
        end
        else
        begin
            lsp = lb + c8;
            if (lsp < SW'(SPEED_FLOOR))
                lsp = SW'(SPEED_FLOOR);
        end
        lsp_c = (lsp > SW'(SPEED_MAX)) ? SW'(SPEED_MAX)
              : ((lsp < SW'(SPEED_REV)) ? SW'(SPEED_REV) : lsp);
        rsp_c = (rsp > SW'(SPEED_MAX)) ? SW'(SPEED_MAX)
              : ((rsp < SW'(SPEED_REV)) ? SW'(SPEED_REV) : rsp);

        if (paused_reg)
        begin
            out_calc = '0;
        end
        else
        begin
            out_calc.drive_on     = 1'b1;
            out_calc.steer_target = dneg_reg ? -$signed({1'b0, smag})
                                             : $signed({1'b0, smag});
            out_calc.left_speed   = lsp_c[15:0];
            out_calc.right_speed  = rsp_c[15:0];
            out_calc.assist_mode  = assist_reg ? MODE_GYRO
                                  : (offline_reg ? MODE_OFFLINE : MODE_HOLDOFF);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            sum_reg       <= '0;
            bias_reg      <= '0;
            last_reg      <= '0;
            kp_reg        <= 16'd1311;
            ki_reg        <= 16'd655;
            kg_reg        <= 16'd1280;
            window_reg    <= 9'd30;
            lbase_reg     <= 7'd20;
            rbase_reg     <= 7'd20;
            boost_reg     <= 7'd10;
            holdoff_reg   <= 16'd300;
        end
        else
        begin
            state_reg <= state_next;

            if (state_reg == S_FIN && (!out_valid_reg || !out_stall))
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (state_reg == S_IDLE && in_valid && !in_data.paused)
            begin
                sum_reg <= sum_sat;
                if (!near)
                    last_reg <= in_data.now_ms;
            end

            if (state_reg == S_BDIV && div_done)
                bias_reg <= nneg_reg ? -$signed(div_q[31:0]) : $signed(div_q[31:0]);

            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    CFG_KP:      kp_reg      <= cfg_data;
                    CFG_KI:      ki_reg      <= cfg_data;
                    CFG_KG:      kg_reg      <= cfg_data;
                    CFG_WINDOW:  window_reg  <= cfg_data[8:0];
                    CFG_LBASE:   lbase_reg   <= cfg_data[6:0];
                    CFG_RBASE:   rbase_reg   <= cfg_data[6:0];
                    CFG_BOOST:   boost_reg   <= cfg_data[6:0];
                    CFG_HOLDOFF: holdoff_reg <= cfg_data;
                    default:     ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    paused_reg  <= in_data.paused;
                    e2_reg      <= e2_calc;
                    assist_reg  <= near && late;
                    offline_reg <= !near;
                    hneg_reg    <= hneg;
                end
            end
            S_HDIV:
            begin
                if (div_done)
                    raw_reg <= raw_calc;
            end
            S_MKP:
            begin
                if (mul_done)
                    acc_reg <= CW'(mul_p);
            end
            S_MKI:
            begin
                if (mul_done)
                    acc_reg <= acc_reg + CW'(mul_p);
            end
            S_MG:
            begin
                if (mul_done)
                begin
                    if (assist_reg)
                        acc_reg <= acc_reg - CW'(gterm);
                    x_reg <= (XW'(e2_reg) <<< RAW_SHIFT) - XW'(gterm);
                end
            end
            S_SCALE:
            begin
                dneg_reg <= assist_reg ? y_calc[YW-1] : e2_reg[E_W-1];
            end
            S_DDIV:
            begin
                if (div_done)
                begin
                    dmag_reg <= (div_q > DIV_W'(DMAG_MAX)) ? DMAG_MAX : div_q[DMAG_W-1:0];
                    nneg_reg <= nb[NB_W-1];
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                    out_reg <= out_calc;
            end
            default:
            begin
            end
        endcase
    end

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `LFPS_ASSERT_IMP(a_mul_done_state, mul_done, state_reg == S_MKP || state_reg == S_MKI || state_reg == S_MG, "multiplier finished outside a multiply step")
    `LFPS_ASSERT_IMP(a_div_done_state, div_done, state_reg == S_HDIV || state_reg == S_DDIV || state_reg == S_BDIV, "divider finished outside a divide step")
    `LFPS_ASSERT_NXT(a_paused_skip, in_valid && !in_stall && in_data.paused, state_reg == S_FIN, "paused item did not skip the update")
    `LFPS_ASSERT_IMP(a_steer_range, out_valid, out_data.steer_target <= 8'sd100 && out_data.steer_target >= -8'sd100, "steering target out of range")

endmodule

`default_nettype wire

// File: bench/line_follow_pi_steering_tb.sv
// self-checking bench for line_follow_pi_steering: directed table, then random control ticks
// predicts or looks up each drive command and checks it against the block's output
// depends on lfps_pkg and the line_follow_pi_steering rtl
`default_nettype none

module line_follow_pi_steering_tb;
    import lfps_pkg::*;

    localparam int SUM_W      = 16;
    localparam int HEAD_W     = 24;
    localparam int WATCHDOG   = 6000;
    localparam int SETTLE     = 400;
    localparam int PHASES     = 8;
    localparam int PHASE_ITEMS = 228;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    in_item_t              in_data = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_item_t             out_data;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    line_follow_pi_steering #(.SUM_BITS(SUM_W), .HEADING_BITS(HEAD_W)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // predictor registers and state
    longint      kp = 1311, ki = 655, kg = 1280, window = 30;
    longint      lbase = 20, rbase = 20, boost = 10;
    logic [31:0] holdoff = 32'd300;
    longint      err_sum = 0;
    longint      head_bias = 0;
    logic [31:0] last_offline = 32'd0;

    out_item_t   cmd_expected[$];
    int          mismatches = 0;
    bit          quiet = 1'b0;
    int          stall_left = 0;
    int          idle_cycles = 0;

    // directed table
    in_item_t    table_in[$];
    bit          table_typed[$];
    out_item_t   table_cmd[$];

    function automatic longint floor_quot(longint x, longint d);
        longint q;
        q = x / d;
        if (x % d != 0 && x < 0)
            q--;
        return q;
    endfunction

    function automatic longint round_quot(longint x, longint d);
        longint m, q;
        m = x < 0 ? -x : x;
        q = (m + d / 2) / d;
        return x < 0 ? -q : q;
    endfunction

    function automatic out_item_t steer_predict(in_item_t x);
        longint e2, lim, c17, c8, raw, g, gterm, d, steer, lsp, rsp, hd, mag;
        logic [1:0] mode;
        out_item_t r;
        r = '0;
        if (x.paused)
            return r;
        e2 = 2 * longint'(x.right_inner) + 3 * longint'(x.right_outer)
           - 2 * longint'(x.left_inner) - 3 * longint'(x.left_outer);
        lim = (longint'(1) <<< (SUM_W - 1)) - 1;
        err_sum = err_sum + e2;
        if (err_sum > lim)
            err_sum = lim;
        if (err_sum < -lim - 1)
            err_sum = -lim - 1;
        c17 = kp * e2 + ki * err_sum;
        hd = longint'(x.heading);
        raw = hd - round_quot(hd, 1440) * 1440;
        g = raw * 65536 - head_bias;
        gterm = floor_quot(g * kg, 2048);
        mag = e2 < 0 ? -e2 : e2;
        if (mag <= window && (x.now_ms - last_offline) >= holdoff)
        begin
            mode = MODE_GYRO;
            c17 = c17 - gterm;
            d = ((e2 * 65536 - gterm) * 7) / 1310720;
            head_bias = round_quot(9 * head_bias + raw * 65536, 10);
        end
        else
        begin
            if (mag > window)
            begin
                mode = MODE_OFFLINE;
                last_offline = x.now_ms;
            end
            else
                mode = MODE_HOLDOFF;
            d = e2 / 6;
        end
        if (d > 0)
        begin
            steer = d > 100 ? 100 : d;
            lsp = (lbase + boost) * 256;
            rsp = d >= 70 ? -256 : 0;
        end
        else if (d == 0)
        begin
            steer = 0;
            lsp = lbase * 256;
            rsp = rbase * 256;
        end
        else
        begin
            steer = d < -100 ? -100 : d;
            rsp = (rbase + boost) * 256;
            lsp = d <= -70 ? -256 : 0;
        end
        c8 = floor_quot(c17, 512);
        if (c17 >= 0)
        begin
            rsp = rbase * 256 - c8;
            if (rsp < 1280)
                rsp = 1280;
        end
        else
        begin
            lsp = lbase * 256 + c8;
            if (lsp < 1280)
                lsp = 1280;
        end
        if (lsp > 28160) lsp = 28160;
        if (lsp < -256) lsp = -256;
        if (rsp > 28160) rsp = 28160;
        if (rsp < -256) rsp = -256;
        r.drive_on = 1'b1;
        r.steer_target = 8'(steer);
        r.left_speed = 16'(lsp);
        r.right_speed = 16'(rsp);
        r.assist_mode = mode;
        return r;
    endfunction

    function automatic in_item_t tick(bit p, int li, int lo, int ri, int ro,
                                      logic [23:0] h, logic [31:0] t);
        in_item_t x;
        x.paused = p;
        x.left_inner = 7'(li);
        x.left_outer = 7'(lo);
        x.right_inner = 7'(ri);
        x.right_outer = 7'(ro);
        x.heading = h;
        x.now_ms = t;
        return x;
    endfunction

    task automatic add_row(in_item_t x, bit typed, out_item_t cmd);
        table_in.insert(table_in.size(), x);
        table_typed.insert(table_typed.size(), typed);
        table_cmd.insert(table_cmd.size(), cmd);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_KP:      kp = longint'(val);
            CFG_KI:      ki = longint'(val);
            CFG_KG:      kg = longint'(val);
            CFG_WINDOW:  window = longint'(val[8:0]);
            CFG_LBASE:   lbase = longint'(val[6:0]);
            CFG_RBASE:   rbase = longint'(val[6:0]);
            CFG_BOOST:   boost = longint'(val[6:0]);
            CFG_HOLDOFF: holdoff = {16'd0, val};
            default: ;
        endcase
    endtask

    task automatic send_tick(in_item_t x, bit typed, out_item_t typed_cmd);
        out_item_t p;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13) - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data <= x;
        do
            @(posedge clk);
        while (in_stall);
        p = steer_predict(x);
        cmd_expected.insert(cmd_expected.size(), typed ? typed_cmd : p);
    endtask

    task automatic drain;
        while (cmd_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // drive command checker and watchdog
    always @(posedge clk)
    begin
        out_item_t e;
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG)
        begin
            $display("line_follow_pi_steering_tb NOT OK");
            $finish;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (cmd_expected.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected drive command %h", out_data);
            end
            else
            begin
                e = cmd_expected.pop_front();
                if (out_data.drive_on !== e.drive_on
                    || out_data.steer_target !== e.steer_target
                    || out_data.left_speed !== e.left_speed
                    || out_data.right_speed !== e.right_speed
                    || out_data.assist_mode !== e.assist_mode)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch exp on=%0d st=%0d l=%0d r=%0d m=%0d",
                            e.drive_on, e.steer_target, e.left_speed, e.right_speed,
                            e.assist_mode);
                        $display("         got on=%0d st=%0d l=%0d r=%0d m=%0d",
                            out_data.drive_on, out_data.steer_target,
                            out_data.left_speed, out_data.right_speed, out_data.assist_mode);
                    end
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (quiet)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            out_stall <= 1'b1;
            stall_left <= $urandom_range(1, 13) - 1;
        end
        else
            out_stall <= 1'b0;
    end

    initial
    begin
        out_item_t   rest_cmd;
        in_item_t    x;
        longint      hd_run;
        logic [31:0] t_run;
        int          kind, b, n;
        logic [15:0] v;

        rest_cmd = '0;
        rest_cmd.drive_on = 1'b1;
        rest_cmd.left_speed = 16'sd5120;
        rest_cmd.right_speed = 16'sd5120;
        rest_cmd.assist_mode = MODE_GYRO;

        // first row runs from reset state with centered sensors
        add_row(tick(0, 0, 0, 0, 0, 24'd0, 32'd1000), 1'b1, rest_cmd);
        add_row(tick(1, 100, 100, 100, 100, 24'hFFFFFF, 32'd1050), 1'b1, '0);
        add_row(tick(0, 100, 100, 0, 0, 24'd0, 32'd1100), 1'b0, '0);
        add_row(tick(0, 0, 0, 100, 100, 24'd0, 32'd1150), 1'b0, '0);
        add_row(tick(0, 0, 0, 0, 0, 24'd720, 32'd1300), 1'b0, '0);
        add_row(tick(0, 0, 0, 0, 0, 24'd720, 32'd1500), 1'b0, '0);
        add_row(tick(0, 0, 0, 0, 0, -24'sd720, 32'd1550), 1'b0, '0);
        add_row(tick(0, 0, 0, 0, 0, 24'd719, 32'd1600), 1'b0, '0);
        add_row(tick(0, 50, 50, 50, 50, 24'h7FFFFF, 32'd1650), 1'b0, '0);
        add_row(tick(0, 50, 50, 50, 50, 24'h800000, 32'd1700), 1'b0, '0);
        add_row(tick(0, 0, 0, 15, 0, 24'd100, 32'd1750), 1'b0, '0);
        add_row(tick(0, 0, 0, 0, 0, 24'd0, 32'd1760), 1'b0, '0);
        add_row(tick(0, 15, 0, 0, 0, -24'sd100, 32'd1800), 1'b0, '0);
        add_row(tick(0, 0, 0, 14, 1, 24'd33, 32'd2200), 1'b0, '0);
        add_row(tick(0, 0, 0, 100, 100, 24'd0, 32'hFFFFFF00), 1'b0, '0);
        add_row(tick(0, 3, 3, 3, 3, 24'd5, 32'd100), 1'b0, '0);
        add_row(tick(0, 3, 3, 3, 3, 24'd5, 32'd400), 1'b0, '0);
        add_row(tick(0, 24, 0, 0, 88, 24'd1440, 32'hFFFFFFFF), 1'b0, '0);
        add_row(tick(1, 0, 0, 0, 0, 24'd0, 32'd0), 1'b1, '0);
        add_row(tick(0, 0, 100, 0, 0, -24'sd2160, 32'd500), 1'b0, '0);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < table_in.size(); i++)
            send_tick(table_in[i], table_typed[i], table_cmd[i]);

        hd_run = 0;
        t_run = 32'd3000;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            drain();
            for (int r = 0; r <= int'(CFG_HOLDOFF); r++)
            begin
                case (ph)
                    0: v = (r == int'(CFG_WINDOW)) ? 16'd500
                         : (r >= int'(CFG_LBASE) && r <= int'(CFG_BOOST)) ? 16'd100
                         : 16'hFFFF;
                    1: v = 16'd0;
                    default:
                    begin
                        case (r)
                            int'(CFG_WINDOW): v = 16'($urandom_range(0, 500));
                            int'(CFG_LBASE), int'(CFG_RBASE), int'(CFG_BOOST):
                                v = 16'($urandom_range(0, 100));
                            int'(CFG_HOLDOFF):
                                v = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                    : 16'($urandom_range(0, 600));
                            default: v = $urandom_range(0, 3) == 0 ? 16'($urandom)
                                         : 16'($urandom_range(0, 3000));
                        endcase
                    end
                endcase
                write_reg(CFG_IDX_W'(r), v);
            end
            write_reg(CFG_IDX_W'($urandom_range(8, 15)), 16'($urandom));
            @(negedge clk);
            cfg_wr_en <= 1'b0;
            quiet = (ph == PHASES - 1);

            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (ph == 3 && i == PHASE_ITEMS / 2)
                begin
                    @(negedge clk);
                    in_valid <= 1'b0;
                    while (cmd_expected.size() != 0)
                        @(posedge clk);
                end
                kind = $urandom_range(0, 15);
                b = $urandom_range(0, 100);
                t_run = t_run + $urandom_range(0, 120);
                if ($urandom_range(0, 40) == 0)
                    t_run = $urandom;
                hd_run = hd_run + $signed($urandom_range(0, 400)) - 200;
                if ($urandom_range(0, 30) == 0)
                    hd_run = $signed(24'($urandom));
                if (kind == 0)
                    x = tick(1, $urandom_range(0, 100), $urandom_range(0, 100),
                             $urandom_range(0, 100), $urandom_range(0, 100),
                             24'($urandom), $urandom);
                else if (kind <= 3)
                    x = tick(0, $urandom_range(0, 100), $urandom_range(0, 100),
                             $urandom_range(0, 100), $urandom_range(0, 100),
                             24'(hd_run), t_run);
                else
                begin
                    n = $urandom_range(0, 6);
                    x = tick(0, b, b, b, b, 24'(hd_run), t_run);
                    x.left_inner = 7'(b < n ? 0 : b - $urandom_range(0, n));
                    x.right_outer = 7'(b + n > 100 ? 100 : b + $urandom_range(0, n));
                    x.left_outer = 7'(b + n > 100 ? 100 : b + $urandom_range(0, n));
                    x.right_inner = 7'(b < n ? 0 : b - $urandom_range(0, n));
                end
                send_tick(x, 1'b0, '0);
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        drain();
        if (mismatches == 0 && cmd_expected.size() == 0)
            $display("line_follow_pi_steering_tb OK");
        else
            $display("line_follow_pi_steering_tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
+incdir+hw/rtl
hw/rtl/lfps_pkg.sv
hw/rtl/lfps_mul.sv
hw/rtl/lfps_div.sv
hw/rtl/line_follow_pi_steering.sv
bench/line_follow_pi_steering_tb.sv
